// ===== src/nonzero_weighted_boxcar_smoother_macros.svh =====
// Assertion macros for the nonzero-weighted boxcar smoother.
// Included by the top level; no other dependencies.
`ifndef NONZERO_WEIGHTED_BOXCAR_SMOOTHER_MACROS_SVH
`define NONZERO_WEIGHTED_BOXCAR_SMOOTHER_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define NWBS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition never occurs.
`define NWBS_ASSERT_NEVER(label, clk, rstn, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error(msg);

`endif

// ===== src/nwbs_pkg.sv =====
// Shared constants, register codes and control structs of the smoother.
// No dependencies; used by every other file except nwbs_ram and the macros header.
`timescale 1ns / 1ps

package nwbs_pkg;

  // Field widths
  localparam int SAMPLE_W   = 16;
  localparam int VALUE_W    = 24;
  localparam int POS_W      = 12;
  localparam int WLEN_W     = 5;
  localparam int SERIES_W   = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Sample ring
  localparam int STORE_DEPTH = 32;
  localparam int STORE_AW    = 5;

  // Longest series
  localparam int MAX_SERIES = 4096;

  // Datapath widths: weight, tail, weight sum, weighted total
  localparam int WT_W    = 5;
  localparam int TAIL_W  = 4;
  localparam int WSUM_W  = 9;
  localparam int TOTAL_W = 24;

  // Divider: quotient bits produced one per cycle
  localparam int DIV_STEPS = 24;
  localparam int DIV_CNT_W = 5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RAMP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SERIES = 2'd2;

  // Configuration reset values
  localparam logic [WLEN_W-1:0]   RST_WINDOW = 5'd15;
  localparam logic                RST_RAMP   = 1'b0;
  localparam logic [SERIES_W-1:0] RST_SERIES = 13'd365;

  typedef struct packed {
    logic [WLEN_W-1:0]   window_length;
    logic                ramp_weights;
    logic [SERIES_W-1:0] series_length;
  } cfg_t;

  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] waddr;
    logic [SAMPLE_W-1:0] wdata;
    logic [STORE_AW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic                       start;
    logic signed [TOTAL_W-1:0]  total;
    logic [WSUM_W-1:0]          wsum;
  } div_req_t;

  typedef struct packed {
    logic                       busy;
    logic                       done;
    logic signed [VALUE_W-1:0]  quot;
  } div_rsp_t;

endpackage

// ===== src/nwbs_intf.sv =====
// Handshake channels of the smoother: sample input, result output, config write.
// Depends on nwbs_pkg for field widths.
`timescale 1ns / 1ps

interface nwbs_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [nwbs_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface nwbs_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [nwbs_pkg::VALUE_W-1:0] smoothed_value;
  logic [nwbs_pkg::POS_W-1:0]          position;
  logic                                config_error;
  logic                                last_of_run;

  modport source (output valid, output smoothed_value, output position,
                  output config_error, output last_of_run, input ready);
  modport sink (input valid, input smoothed_value, input position,
                input config_error, input last_of_run, output ready);
endinterface

interface nwbs_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [nwbs_pkg::CFG_IDX_W-1:0]    index;
  logic [nwbs_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/nonzero_weighted_boxcar_smoother.sv =====
// Usage: nonzero-weighted boxcar smoother over a streamed series.
// Channels: sample_i takes one signed sample per item; result_o returns
// smoothed value, position, error and last-of-run flags; cfg_i writes the
// window length (index 0), ramp mode (index 1) and series length (index 2).
// Write configuration only while no item is in flight.
// Processing: each result is formed by a tap walk over the W taps (W = odd
// window, up to 31) through the one-read-port sample RAM, then the 24-step
// divider. A window with no nonzero sample skips the divider.
// Throughput: one item at a time; the last sample of a series emits up to
// 16 results one after another. An early sample that makes no result frees
// the input in the next cycle; an error item skips the tap walk and divider.
// Reset: configuration returns to 15 / equal weights / 365, the sample
// index to zero. The sample RAM is not cleared; only stored samples are read.
// Stall: a finished result waits in the output register; the block keeps
// taking items and computing until it has a second result to hand over.
`timescale 1ns / 1ps
`include "nonzero_weighted_boxcar_smoother_macros.svh"

module nonzero_weighted_boxcar_smoother (
  input  logic           clk_i,
  input  logic           rst_ni,
  nwbs_cfg_if.sink       cfg_i,
  nwbs_sample_if.sink    sample_i,
  nwbs_result_if.source  result_o
);

  nwbs_pkg::cfg_t                cfg_q;
  nwbs_pkg::mem_req_t            mem_req;
  logic [nwbs_pkg::SAMPLE_W-1:0] mem_rdata;
  nwbs_pkg::div_req_t            div_req;
  nwbs_pkg::div_rsp_t            div_rsp;

  assign cfg_i.ready = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_length <= nwbs_pkg::RST_WINDOW;
      cfg_q.ramp_weights  <= nwbs_pkg::RST_RAMP;
      cfg_q.series_length <= nwbs_pkg::RST_SERIES;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        nwbs_pkg::CFG_IDX_WINDOW: begin
          cfg_q.window_length <= cfg_i.data[nwbs_pkg::WLEN_W-1:0];
        end
        nwbs_pkg::CFG_IDX_RAMP: begin
          cfg_q.ramp_weights <= cfg_i.data[0];
        end
        nwbs_pkg::CFG_IDX_SERIES: begin
          cfg_q.series_length <= cfg_i.data[nwbs_pkg::SERIES_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Sample ring, indexed by position modulo its depth
  nwbs_ram #(
    .WIDTH(nwbs_pkg::SAMPLE_W),
    .DEPTH(nwbs_pkg::STORE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  nwbs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  nwbs_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .sample_i    (sample_i),
    .result_o    (result_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp)
  );

  // Checks
  `NWBS_ASSERT_IMP(a_div_nonzero, clk_i, rst_ni, div_req.start, div_req.wsum != '0, "divider started with zero weight sum")
  `NWBS_ASSERT_NEVER(a_div_overlap, clk_i, rst_ni, div_req.start && div_rsp.busy, "divider restarted while busy")
  `NWBS_ASSERT_IMP(a_write_on_accept, clk_i, rst_ni, mem_req.we, sample_i.valid && sample_i.ready, "sample RAM written without an accepted item")
  `NWBS_ASSERT_IMP(a_err_result, clk_i, rst_ni, result_o.valid && result_o.config_error, result_o.smoothed_value == '0 && result_o.last_of_run, "error result carries a value or is not last")

endmodule

// ===== src/nwbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module nwbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/nwbs_div.sv =====
// Sequential signed divider: (total * 256) / wsum, truncated toward zero.
// One quotient bit per cycle; depends on nwbs_pkg.
`timescale 1ns / 1ps

module nwbs_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nwbs_pkg::div_req_t req_i,
  output nwbs_pkg::div_rsp_t rsp_o
);

  logic                                busy_q;
  logic                                done_q;
  logic [nwbs_pkg::DIV_CNT_W-1:0]      cnt_q;
  logic [nwbs_pkg::WSUM_W-1:0]         rem_q;
  logic [nwbs_pkg::DIV_STEPS-1:0]      sh_q;
  logic [nwbs_pkg::WSUM_W-1:0]         den_q;
  logic                                neg_q;
  logic signed [nwbs_pkg::VALUE_W-1:0] quot_q;

  logic [nwbs_pkg::TOTAL_W-1:0]  mag;
  logic [nwbs_pkg::WSUM_W:0]     trial;
  logic [nwbs_pkg::WSUM_W:0]     diff;
  logic                          ge;
  logic [nwbs_pkg::DIV_STEPS-1:0] sh_d;
  logic [nwbs_pkg::WSUM_W-1:0]   rem_d;

  // Magnitude of the numerator before scaling by 256
  assign mag = req_i.total[nwbs_pkg::TOTAL_W-1] ? nwbs_pkg::TOTAL_W'(-req_i.total)
                                                : nwbs_pkg::TOTAL_W'(req_i.total);

  // One restoring step
  assign trial = {rem_q, sh_q[nwbs_pkg::DIV_STEPS-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});
  assign rem_d = ge ? diff[nwbs_pkg::WSUM_W-1:0] : trial[nwbs_pkg::WSUM_W-1:0];
  assign sh_d  = {sh_q[nwbs_pkg::DIV_STEPS-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        // Top eight numerator bits are below the divisor, so start past them
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= {1'b0, mag[nwbs_pkg::TOTAL_W-1:nwbs_pkg::TOTAL_W-8]};
        sh_q   <= {mag[nwbs_pkg::TOTAL_W-9:0], 8'h00};
        den_q  <= req_i.wsum;
        neg_q  <= req_i.total[nwbs_pkg::TOTAL_W-1];
      end else if (busy_q) begin
        rem_q <= rem_d;
        sh_q  <= sh_d;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == nwbs_pkg::DIV_CNT_W'(nwbs_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          quot_q <= neg_q ? -$signed(sh_d) : $signed(sh_d);
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// ===== src/nwbs_seq.sv =====
// Sequencer of the smoother: takes samples, walks window taps through the
// sample RAM, accumulates, drives the divider and holds the result register.
// Depends on nwbs_pkg and nwbs_intf.
`timescale 1ns / 1ps

module nwbs_seq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  nwbs_pkg::cfg_t                 cfg_i,
  nwbs_sample_if.sink                    sample_i,
  nwbs_result_if.source                  result_o,
  output nwbs_pkg::mem_req_t             mem_req_o,
  input  logic [nwbs_pkg::SAMPLE_W-1:0]  mem_rdata_i,
  output nwbs_pkg::div_req_t             div_req_o,
  input  nwbs_pkg::div_rsp_t             div_rsp_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAP,
    S_FLUSH,
    S_DIV,
    S_WAIT,
    S_EMIT
  } state_e;

  state_e                              state_q;
  logic [nwbs_pkg::POS_W-1:0]          k_q;
  logic [nwbs_pkg::POS_W-1:0]          k_item_q;
  logic [nwbs_pkg::POS_W-1:0]          p_q;
  logic [nwbs_pkg::POS_W-1:0]          p_end_q;
  logic signed [nwbs_pkg::POS_W:0]     base_q;
  logic [nwbs_pkg::WLEN_W-1:0]         j_q;
  logic [nwbs_pkg::WLEN_W-1:0]         wsize_q;
  logic                                ramp_q;
  logic                                err_q;
  logic                                tap_en_q;
  logic [nwbs_pkg::WT_W-1:0]           tap_wt_q;
  logic signed [nwbs_pkg::TOTAL_W-1:0] total_q;
  logic [nwbs_pkg::WSUM_W-1:0]         wsum_q;
  logic signed [nwbs_pkg::VALUE_W-1:0] value_q;
  logic                                out_vld_q;
  logic signed [nwbs_pkg::VALUE_W-1:0] out_value_q;
  logic [nwbs_pkg::POS_W-1:0]          out_pos_q;
  logic                                out_err_q;
  logic                                out_last_q;

  logic                                accept;
  logic [nwbs_pkg::SERIES_W-1:0]       n_eff;
  logic [nwbs_pkg::SERIES_W-1:0]       k_inc;
  logic                                is_last;
  logic                                cfg_err;
  logic [nwbs_pkg::WLEN_W-1:0]         w_odd;
  logic [nwbs_pkg::TAIL_W-1:0]         tail;
  logic                                early;
  logic [nwbs_pkg::POS_W-1:0]          p_first;
  logic signed [nwbs_pkg::POS_W+1:0]   q_s;
  logic                                in_range;
  logic [nwbs_pkg::WLEN_W-1:0]         wt_a;
  logic [nwbs_pkg::WLEN_W-1:0]         wt_b;
  logic [nwbs_pkg::WT_W-1:0]           wt;
  logic signed [21:0]                  prod;
  logic                                out_free;

  assign accept   = sample_i.valid && sample_i.ready;
  assign out_free = !out_vld_q || result_o.ready;

  // Effective series length, clamped to 1..MAX_SERIES
  always_comb begin
    if (cfg_i.series_length == '0) begin
      n_eff = nwbs_pkg::SERIES_W'(1);
    end else if (cfg_i.series_length > nwbs_pkg::SERIES_W'(nwbs_pkg::MAX_SERIES)) begin
      n_eff = nwbs_pkg::SERIES_W'(nwbs_pkg::MAX_SERIES);
    end else begin
      n_eff = cfg_i.series_length;
    end
  end

  // Classify the incoming item
  assign k_inc   = {1'b0, k_q} + nwbs_pkg::SERIES_W'(1);
  assign is_last = (k_inc >= n_eff);
  assign cfg_err = ({8'b0, cfg_i.window_length} > (n_eff >> 1));
  assign w_odd   = cfg_i.window_length | nwbs_pkg::WLEN_W'(1);
  assign tail    = w_odd[nwbs_pkg::WLEN_W-1:1];
  assign early   = (k_q < {8'b0, tail});
  assign p_first = early ? '0 : k_q - {8'b0, tail};

  // Tap address and weight
  assign q_s      = {base_q[nwbs_pkg::POS_W], base_q} + $signed({9'b0, j_q});
  assign in_range = !q_s[nwbs_pkg::POS_W+1] && (q_s[nwbs_pkg::POS_W:0] <= {1'b0, k_item_q});
  assign wt_a     = j_q + nwbs_pkg::WLEN_W'(1);
  assign wt_b     = wsize_q - j_q;
  assign wt       = ramp_q ? ((wt_a < wt_b) ? wt_a : wt_b) : nwbs_pkg::WT_W'(1);

  // Weighted tap value from RAM data
  assign prod = $signed(mem_rdata_i) * $signed({1'b0, tap_wt_q});

  // RAM port: store on accept, read the current tap
  assign mem_req_o.we    = accept;
  assign mem_req_o.waddr = k_q[nwbs_pkg::STORE_AW-1:0];
  assign mem_req_o.wdata = sample_i.sample;
  assign mem_req_o.raddr = q_s[nwbs_pkg::STORE_AW-1:0];

  // Divider request
  assign div_req_o.start = (state_q == S_DIV) && (wsum_q != '0);
  assign div_req_o.total = total_q;
  assign div_req_o.wsum  = wsum_q;

  assign sample_i.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      k_q       <= '0;
      tap_en_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      // Accumulate a tap read in the previous cycle
      if (tap_en_q && (mem_rdata_i != '0)) begin
        total_q <= total_q + {{2{prod[21]}}, prod};
        wsum_q  <= wsum_q + {4'b0, tap_wt_q};
      end
      tap_en_q <= 1'b0;

      // Drop the result once taken
      if (out_vld_q && result_o.ready) begin
        out_vld_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            k_q      <= is_last ? '0 : k_inc[nwbs_pkg::POS_W-1:0];
            k_item_q <= k_q;
            wsize_q  <= w_odd;
            ramp_q   <= cfg_i.ramp_weights;
            j_q      <= '0;
            total_q  <= '0;
            wsum_q   <= '0;
            if (cfg_err) begin
              err_q   <= 1'b1;
              value_q <= '0;
              p_q     <= k_q;
              p_end_q <= k_q;
              state_q <= S_EMIT;
            end else if (is_last || !early) begin
              err_q   <= 1'b0;
              p_q     <= p_first;
              p_end_q <= is_last ? k_q : p_first;
              base_q  <= $signed({1'b0, p_first}) - $signed({9'b0, tail});
              state_q <= S_TAP;
            end
          end
        end
        S_TAP: begin
          tap_en_q <= in_range;
          tap_wt_q <= wt;
          if (j_q == wsize_q - nwbs_pkg::WLEN_W'(1)) begin
            state_q <= S_FLUSH;
          end else begin
            j_q <= j_q + nwbs_pkg::WLEN_W'(1);
          end
        end
        S_FLUSH: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (wsum_q == '0) begin
            value_q <= '0;
            state_q <= S_EMIT;
          end else begin
            state_q <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (div_rsp_i.done) begin
            value_q <= div_rsp_i.quot;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_vld_q   <= 1'b1;
            out_value_q <= value_q;
            out_pos_q   <= p_q;
            out_err_q   <= err_q;
            out_last_q  <= (p_q == p_end_q);
            if (p_q == p_end_q) begin
              state_q <= S_IDLE;
            end else begin
              // Advance to the next pending position
              p_q     <= p_q + nwbs_pkg::POS_W'(1);
              base_q  <= base_q + $signed({{nwbs_pkg::POS_W{1'b0}}, 1'b1});
              j_q     <= '0;
              total_q <= '0;
              wsum_q  <= '0;
              state_q <= S_TAP;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign result_o.valid          = out_vld_q;
  assign result_o.smoothed_value = out_value_q;
  assign result_o.position       = out_pos_q;
  assign result_o.config_error   = out_err_q;
  assign result_o.last_of_run    = out_last_q;

endmodule

// ===== tb/nonzero_weighted_boxcar_smoother_test.sv =====
// Self-checking testbench for the nonzero-weighted boxcar smoother.
// Uses nwbs_pkg and the channel interfaces of nwbs_intf; drives directed rows, then random series.
`timescale 1ns / 1ps

module nonzero_weighted_boxcar_smoother_test;
  import nwbs_pkg::*;

  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_ITEMS  = 305;
  localparam int PLAN_ROWS     = 35;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
    logic                      config_error;
    logic                      last_of_run;
  } result_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  typedef struct packed {
    row_kind_e                  kind;
    logic [CFG_IDX_W-1:0]       idx;
    logic [CFG_DATA_W-1:0]      data;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       typed;
    result_t                    outcome;
  } row_t;

  // Directed rows; outcome is used only where typed is set
  localparam row_t PLAN [PLAN_ROWS] = '{
    // one sample at the reset settings: too early for any result
    '{ROW_SAMPLE, CFG_IDX_WINDOW, 13'd0, 16'sd0, 1'b0, '{24'd0, 12'd0, 1'b0, 1'b0}},
    // window too long for a one-sample series: error per item
    '{ROW_WRITE, CFG_IDX_SERIES, 13'd1, 16'sd0, 1'b0, '{24'd0, 12'd0, 1'b0, 1'b0}},
    '{ROW_WRITE, CFG_IDX_WINDOW, 13'd31, 16'sd0, 1'b0, '{24'd0, 12'd0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, CFG_IDX_WINDOW, 13'd0, 16'sh7FFF, 1'b1, '{24'd0, 12'd1, 1'b1, 1'b1}},
    '{ROW_SAMPLE, CFG_IDX_WINDOW, 13'd0, 16'sh8000, 1'b1, '{24'd0, 12'd0, 1'b1, 1'b1}},
    // window of one: the sample itself comes back scaled
    '{ROW_WRITE, CFG_IDX_WINDOW, 13'd0, 16'sd0, 1'b0, '{24'd0, 12'd0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, CFG_IDX_WINDOW, 13'd0, 16'sh8000, 1'b1, '{24'h800000, 12'd0, 1'b0, 1'b1}},
    '{ROW_SAMPLE, CFG_IDX_WINDOW, 13'd0, 16'sh7FFF, 1'b1, '{24'd8388352, 12'd0, 1'b0, 1'b1}},
    '{ROW_SAMPLE, CFG_IDX_WINDOW, 13'd0, 16'sd0, 1'b1, '{24'd0, 12'd0, 1'b0, 1'b1}},
    // ramp on, series length zero clamps to one
    '{ROW_WRITE, CFG_IDX_RAMP, 13'd1, 16'sd0, 1'b0, '{24'd0, 12'd0, 1'b0, 1'b0}},
    '{ROW_WRITE, CFG_IDX_SERIES, 13'd0, 16'sd0, 1'b0, '{24'd0, 12'd0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, CFG_IDX_WINDOW, 13'd0, 16'sd1, 1'b1, '{24'd256, 12'd0, 1'b0, 1'b1}},
    // longest series and widest ramp window
    '{ROW_WRITE, CFG_IDX_SERIES, 13'd8191, 16'sd0, 1'b0, '{24'd0, 12'd0, 1'b0, 1'b0}},
    '{ROW_WRITE, CFG_IDX_WINDOW, 13'd31, 16'sd0, 1'b0, '{24'd0, 12'd0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, CFG_IDX_WINDOW, 13'd0, 16'sd100, 1'b0, '{24'd0, 12'd0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, CFG_IDX_WINDOW, 13'd0, 16'sd0, 1'b0, '{24'd0, 12'd0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, CFG_IDX_WINDOW, 13'd0, 16'sh8000, 1'b0, '{24'd0, 12'd0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, CFG_IDX_WINDOW, 13'd0, 16'sh7FFF, 1'b0, '{24'd0, 12'd0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, CFG_IDX_WINDOW, 13'd0, 16'sd0, 1'b0, '{24'd0, 12'd0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, CFG_IDX_WINDOW, 13'd0, 16'sd0, 1'b0, '{24'd0, 12'd0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, CFG_IDX_WINDOW, 13'd0, 16'sd1, 1'b0, '{24'd0, 12'd0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, CFG_IDX_WINDOW, 13'd0, 16'shFFFF, 1'b0, '{24'd0, 12'd0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, CFG_IDX_WINDOW, 13'd0, 16'sh5555, 1'b0, '{24'd0, 12'd0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, CFG_IDX_WINDOW, 13'd0, 16'shAAAA, 1'b0, '{24'd0, 12'd0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, CFG_IDX_WINDOW, 13'd0, 16'sd0, 1'b0, '{24'd0, 12'd0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, CFG_IDX_WINDOW, 13'd0, 16'sd7, 1'b0, '{24'd0, 12'd0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, CFG_IDX_WINDOW, 13'd0, -16'sd300, 1'b0, '{24'd0, 12'd0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, CFG_IDX_WINDOW, 13'd0, 16'sd12345, 1'b0, '{24'd0, 12'd0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, CFG_IDX_WINDOW, 13'd0, 16'sd0, 1'b0, '{24'd0, 12'd0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, CFG_IDX_WINDOW, 13'd0, -16'sd4096, 1'b0, '{24'd0, 12'd0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, CFG_IDX_WINDOW, 13'd0, 16'sh7FFF, 1'b0, '{24'd0, 12'd0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, CFG_IDX_WINDOW, 13'd0, 16'sd2, 1'b0, '{24'd0, 12'd0, 1'b0, 1'b0}},
    // shrink window and series mid-series: next sample ends the series
    '{ROW_WRITE, CFG_IDX_WINDOW, 13'd4, 16'sd0, 1'b0, '{24'd0, 12'd0, 1'b0, 1'b0}},
    '{ROW_WRITE, CFG_IDX_SERIES, 13'd10, 16'sd0, 1'b0, '{24'd0, 12'd0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, CFG_IDX_WINDOW, 13'd0, 16'sd5, 1'b0, '{24'd0, 12'd0, 1'b0, 1'b0}}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  nwbs_cfg_if    cfg_bus ();
  nwbs_sample_if sample_bus ();
  nwbs_result_if result_bus ();

  nonzero_weighted_boxcar_smoother dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_bus),
    .sample_i (sample_bus),
    .result_o (result_bus)
  );

  always #1 clk_i = ~clk_i;

  // Shadow of the block: settings, sample ring, series index
  logic [WLEN_W-1:0]          window_setting = RST_WINDOW;
  logic                       ramp_setting   = RST_RAMP;
  logic [SERIES_W-1:0]        series_setting = RST_SERIES;
  logic signed [SAMPLE_W-1:0] sample_ring [STORE_DEPTH];
  int                         series_index   = 0;

  result_t pending_results [$];
  result_t step_results [$];
  int      mismatches  = 0;
  bit      steady_phase = 1'b0;

  // Weighted mean of the nonzero samples around pos, window clipped to [0, hi]
  function automatic logic signed [VALUE_W-1:0] weighted_mean(int pos, int wsize, int hi);
    longint total;
    longint wsum;
    longint wt;
    int     tail;
    int     q;
    total = 0;
    wsum  = 0;
    tail  = wsize / 2;
    for (int j = 0; j < wsize; j++) begin
      q = pos + j - tail;
      if (q < 0 || q > hi) continue;
      if (sample_ring[q % STORE_DEPTH] == 0) continue;
      wt = 1;
      if (ramp_setting) wt = longint'((j + 1 < wsize - j) ? j + 1 : wsize - j);
      total += longint'(sample_ring[q % STORE_DEPTH]) * wt;
      wsum  += wt;
    end
    if (wsum == 0) return '0;
    return VALUE_W'((total * 256) / wsum);
  endfunction

  // Store one sample, advance the series index and list the results it causes
  function automatic void advance_series(logic signed [SAMPLE_W-1:0] s);
    int n;
    int k;
    int w;
    int tail;
    int pos;
    bit ends;
    step_results.delete();
    n = int'(series_setting);
    if (n < 1) n = 1;
    if (n > MAX_SERIES) n = MAX_SERIES;
    k    = series_index;
    ends = (k + 1 >= n);
    sample_ring[k % STORE_DEPTH] = s;
    series_index = ends ? 0 : k + 1;
    w = int'(window_setting);
    if (w > n / 2) begin
      step_results.push_back('{'0, POS_W'(k), 1'b1, 1'b1});
      return;
    end
    if (w % 2 == 0) w++;
    tail = w / 2;
    pos  = k - tail;
    if (!ends) begin
      if (pos >= 0) step_results.push_back('{weighted_mean(pos, w, k), POS_W'(pos), 1'b0, 1'b1});
    end else begin
      if (pos < 0) pos = 0;
      for (; pos <= k; pos++) begin
        step_results.push_back('{weighted_mean(pos, w, k), POS_W'(pos), 1'b0, pos == k});
      end
    end
  endfunction

  // Mostly no pause, sometimes a short one, rarely a long one
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] draw_sample(int zero_pct);
    if ($urandom_range(0, 99) < zero_pct) return '0;
    if ($urandom_range(0, 19) == 0) begin
      case ($urandom_range(0, 3))
        0: return 16'sh8000;
        1: return 16'sh7FFF;
        2: return 16'shFFFF;
        default: return 16'sd1;
      endcase
    end
    return SAMPLE_W'($urandom_range(0, 65535));
  endfunction

  // Write one register; valid stays high for a following write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    case (idx)
      CFG_IDX_WINDOW: window_setting = value[WLEN_W-1:0];
      CFG_IDX_RAMP:   ramp_setting   = value[0];
      CFG_IDX_SERIES: series_setting = value[SERIES_W-1:0];
      default: ;
    endcase
  endtask

  // Offer one sample after a gap; queue its results once it is taken
  task automatic send_sample(logic signed [SAMPLE_W-1:0] s, int gap, logic typed,
                             result_t outcome);
    if (gap > 0) begin
      sample_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_bus.valid  <= 1'b1;
    sample_bus.sample <= s;
    @(posedge clk_i);
    while (!sample_bus.ready) @(posedge clk_i);
    advance_series(s);
    if (typed) pending_results.push_back(outcome);
    else foreach (step_results[i]) pending_results.push_back(step_results[i]);
  endtask

  // Hold input until every awaited result is out, then let the block drain
  task automatic settle();
    sample_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Result receiver: random stalls except in steady phases
  initial begin
    int stall_left;
    stall_left       = 0;
    result_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        result_bus.ready <= 1'b0;
      end else if (steady_phase) begin
        result_bus.ready <= 1'b1;
      end else if (stall_left > 0) begin
        result_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        result_bus.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pause_len();
      end
    end
  end

  // Compare each result taken with the oldest awaited one
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: position %0d value %0d", result_bus.position,
               result_bus.smoothed_value);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (result_bus.smoothed_value !== want.value) begin
          $error("smoothed_value: expected %0d, got %0d", want.value,
                 result_bus.smoothed_value);
          mismatches++;
        end
        if (result_bus.position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, result_bus.position);
          mismatches++;
        end
        if (result_bus.config_error !== want.config_error) begin
          $error("config_error: expected %0d, got %0d", want.config_error,
                 result_bus.config_error);
          mismatches++;
        end
        if (result_bus.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                 result_bus.last_of_run);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    bit streaming;
    int sent;
    int count;
    int n_eff;
    int zero_pct;
    logic [CFG_DATA_W-1:0] series_data;
    logic [CFG_DATA_W-1:0] window_data;

    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = CFG_IDX_WINDOW;
    cfg_bus.data      = '0;
    sample_bus.valid  = 1'b0;
    sample_bus.sample = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed rows
    streaming = 1'b0;
    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_WRITE) begin
        if (streaming) settle();
        streaming = 1'b0;
        write_reg(PLAN[i].idx, PLAN[i].data);
      end else begin
        cfg_bus.valid <= 1'b0;
        streaming = 1'b1;
        send_sample(PLAN[i].sample, pause_len(), PLAN[i].typed, PLAN[i].outcome);
      end
    end

    // Random phases: new settings while idle, then a burst of samples
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      steady_phase = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: series_data = CFG_DATA_W'($urandom_range(65, 8191));
        1: series_data = CFG_DATA_W'($urandom_range(0, 2));
        default: series_data = CFG_DATA_W'($urandom_range(3, 64));
      endcase
      n_eff = (series_data == 0) ? 1 :
              (int'(series_data) > MAX_SERIES) ? MAX_SERIES : int'(series_data);
      if ($urandom_range(0, 4) == 0) window_data = CFG_DATA_W'($urandom_range(0, 31));
      else window_data = CFG_DATA_W'($urandom_range(0, (n_eff / 2 > 31) ? 31 : n_eff / 2));
      write_reg(CFG_IDX_WINDOW, window_data);
      write_reg(CFG_IDX_RAMP, CFG_DATA_W'($urandom_range(0, 1)));
      write_reg(CFG_IDX_SERIES, series_data);
      cfg_bus.valid <= 1'b0;
      case ($urandom_range(0, 3))
        0: zero_pct = 0;
        1: zero_pct = 90;
        default: zero_pct = 25;
      endcase
      count = $urandom_range(4, 45);
      repeat (count) begin
        send_sample(draw_sample(zero_pct), steady_phase ? 0 : pause_len(), 1'b0, '0);
      end
      sent += count;
    end

    settle();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/nwbs_pkg.sv
src/nwbs_intf.sv
src/nwbs_ram.sv
src/nwbs_div.sv
src/nwbs_seq.sv
src/nonzero_weighted_boxcar_smoother.sv
tb/nonzero_weighted_boxcar_smoother_test.sv
